// ----- rtl/dhvp_pkg.sv -----
// dhvp_pkg: shared types, character codes and the hex digit decoder
// for the dotted hex version parser; no dependencies
package dhvp_pkg;

   localparam int CHAR_WIDTH  = 8;
   localparam int VALUE_WIDTH = 24;
   localparam int BYTE_WIDTH  = 8;
   localparam int NIBBLE_WIDTH = 4;
   localparam int REQ_DATA_WIDTH = 8;
   localparam int RSP_DATA_WIDTH = 32;

   localparam logic [CHAR_WIDTH-1:0] CHAR_NUL = 8'h00;
   localparam logic [CHAR_WIDTH-1:0] CHAR_DOT = 8'h2E;
   localparam logic [CHAR_WIDTH-1:0] CHAR_0   = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_9   = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LA  = 8'h61;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LF  = 8'h66;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UA  = 8'h41;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UF  = 8'h46;
   localparam logic [CHAR_WIDTH-1:0] HEX_TEN  = 8'h0A;

   typedef enum logic [1:0] {
      PH_FIRST = 2'd0,
      PH_MORE  = 2'd1,
      PH_DELIM = 2'd2
   } phase_type;

   typedef struct packed {
      logic                  valid;
      logic [CHAR_WIDTH-1:0] char_code;
   } item_type;

   typedef struct packed {
      logic                    is_hex;
      logic [NIBBLE_WIDTH-1:0] value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [CHAR_WIDTH-1:0] ch);
      hex_type                res;
      logic [CHAR_WIDTH-1:0]  diff;
      res  = '0;
      diff = '0;
      if (ch >= CHAR_0 && ch <= CHAR_9) begin
         diff = ch - CHAR_0;
         res.is_hex = 1'b1;
      end else if (ch >= CHAR_LA && ch <= CHAR_LF) begin
         diff = ch - CHAR_LA + HEX_TEN;
         res.is_hex = 1'b1;
      end else if (ch >= CHAR_UA && ch <= CHAR_UF) begin
         diff = ch - CHAR_UA + HEX_TEN;
         res.is_hex = 1'b1;
      end
      res.value = diff[NIBBLE_WIDTH-1:0];
      return res;
   endfunction

endpackage

// ----- rtl/dhvp_in_stage.sv -----
// dhvp_in_stage: input register for one character transfer
// depends on dhvp_pkg
module dhvp_in_stage (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [dhvp_pkg::REQ_DATA_WIDTH-1:0] req_tdata,  // char_code
   input  logic                                take,
   output dhvp_pkg::item_type                  item
);

   logic                                valid_ff, valid_in;
   logic [dhvp_pkg::CHAR_WIDTH-1:0]     char_ff, char_in;

   assign req_tready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      char_in  = char_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
         char_in  = req_tdata[dhvp_pkg::CHAR_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      char_ff <= char_in;
   end

   assign item.valid     = valid_ff;
   assign item.char_code = char_ff;

endmodule

// ----- rtl/dhvp_parser.sv -----
// dhvp_parser: parse state machine, component registers and result register
// depends on dhvp_pkg
module dhvp_parser #(
   parameter int NUM_COMPONENTS       = 3,
   parameter int DIGITS_PER_COMPONENT = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dhvp_pkg::item_type                  item,
   output logic                                take,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [dhvp_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata  // ok, version_value
);

   localparam int CW  = dhvp_pkg::NIBBLE_WIDTH * DIGITS_PER_COMPONENT;
   localparam int CIW = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;
   localparam int DCW = $clog2(DIGITS_PER_COMPONENT + 1);
   localparam int VW  = dhvp_pkg::VALUE_WIDTH;

   dhvp_pkg::phase_type   phase_ff, phase_in;
   logic                  failed_ff, failed_in;
   logic [DCW-1:0]        count_ff, count_in;
   logic [CIW-1:0]        index_ff, index_in;
   logic [CW-1:0]         comp_ff [NUM_COMPONENTS];
   logic [CW-1:0]         comp_in [NUM_COMPONENTS];
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  ok_ff, ok_in;
   logic [VW-1:0]         value_ff, value_in;

   dhvp_pkg::hex_type     hex;
   logic                  is_nul;
   logic                  good;
   logic                  last_index;
   logic [VW-1:0]         packed_v;

   assign is_nul     = item.char_code == dhvp_pkg::CHAR_NUL;
   assign take       = item.valid && (!is_nul || !rsp_valid_ff || rsp_tready);
   assign hex        = dhvp_pkg::hex_decode(item.char_code);
   assign good       = !failed_ff && phase_ff != dhvp_pkg::PH_FIRST;
   assign last_index = index_ff == CIW'(NUM_COMPONENTS - 1);

   always_comb begin
      packed_v = '0;
      for (int i = 0; i < NUM_COMPONENTS; i++) begin
         packed_v = (packed_v << dhvp_pkg::BYTE_WIDTH) + VW'(comp_ff[i]);
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      failed_in = failed_ff;
      count_in  = count_ff;
      index_in  = index_ff;
      comp_in   = comp_ff;
      if (take) begin
         if (is_nul) begin
            phase_in  = dhvp_pkg::PH_FIRST;
            failed_in = 1'b0;
            count_in  = '0;
            index_in  = '0;
            for (int i = 0; i < NUM_COMPONENTS; i++) begin
               comp_in[i] = '0;
            end
         end else if (!failed_ff) begin
            if (item.char_code == dhvp_pkg::CHAR_DOT) begin
               if (phase_ff == dhvp_pkg::PH_FIRST || last_index) begin
                  failed_in = 1'b1;
               end else begin
                  index_in = index_ff + CIW'(1);
                  count_in = '0;
                  phase_in = dhvp_pkg::PH_FIRST;
               end
            end else if (!hex.is_hex) begin
               failed_in = 1'b1;
            end else begin
               unique case (phase_ff)
                  dhvp_pkg::PH_FIRST: begin
                     if (hex.value == '0) begin
                        phase_in = dhvp_pkg::PH_DELIM;
                     end else begin
                        comp_in[index_ff] = CW'(hex.value);
                        count_in = DCW'(1);
                        phase_in = dhvp_pkg::PH_MORE;
                     end
                  end
                  dhvp_pkg::PH_MORE: begin
                     if (count_ff >= DCW'(DIGITS_PER_COMPONENT)) begin
                        failed_in = 1'b1;
                     end else begin
                        count_in = count_ff + DCW'(1);
                        comp_in[index_ff] = CW'({comp_ff[index_ff], hex.value});
                     end
                  end
                  dhvp_pkg::PH_DELIM: begin
                     failed_in = 1'b1;
                  end
                  default: begin
                     failed_in = 1'b1;
                  end
               endcase
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ok_in        = ok_ff;
      value_in     = value_ff;
      if (take && is_nul) begin
         rsp_valid_in = 1'b1;
         ok_in        = good;
         value_in     = good ? packed_v : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= dhvp_pkg::PH_FIRST;
         failed_ff    <= 1'b0;
         count_ff     <= '0;
         index_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_COMPONENTS; i++) begin
            comp_ff[i] <= '0;
         end
      end else begin
         phase_ff     <= phase_in;
         failed_ff    <= failed_in;
         count_ff     <= count_in;
         index_ff     <= index_in;
         rsp_valid_ff <= rsp_valid_in;
         comp_ff      <= comp_in;
      end
      ok_ff    <= ok_in;
      value_ff <= value_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(dhvp_pkg::RSP_DATA_WIDTH - VW - 1){1'b0}}, value_ff, ok_ff};

   a_fail_sticky: assert property (@(posedge clock) disable iff (reset)
      failed_ff && !(take && is_nul) |=> failed_ff)
      else $error("failure flag dropped before end of string");

   a_nul_restarts: assert property (@(posedge clock) disable iff (reset)
      take && is_nul |=> phase_ff == dhvp_pkg::PH_FIRST && !failed_ff && index_ff == '0)
      else $error("parser not restarted after end of string");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !ok_ff |-> value_ff == '0)
      else $error("failed result carries a nonzero value");

   a_delim_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == dhvp_pkg::PH_DELIM |-> count_ff == '0)
      else $error("digit count set after lone zero");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      index_ff <= CIW'(NUM_COMPONENTS - 1))
      else $error("component index out of range");

endmodule

// ----- rtl/dotted_hex_version_parser_core.sv -----
// dotted_hex_version_parser_core: a terminating NUL passes the input register and then
// the result register before its result shows on rsp; other characters give no result
// throughput is one character per cycle, as the parse step between the input register
// and the result register is combinational; a NUL waits only while
// the result register is still full and not being taken
// reset clears the parse state, component registers and both valid flags
module dotted_hex_version_parser_core #(
   parameter int NUM_COMPONENTS       = 3,
   parameter int DIGITS_PER_COMPONENT = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [dhvp_pkg::REQ_DATA_WIDTH-1:0] req_tdata,  // char_code[7:0]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [dhvp_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata   // ok[0], version_value[24:1]
);

   dhvp_pkg::item_type item;
   logic               take;

   dhvp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .take       (take),
      .item       (item)
   );

   dhvp_parser #(
      .NUM_COMPONENTS       (NUM_COMPONENTS),
      .DIGITS_PER_COMPONENT (DIGITS_PER_COMPONENT)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
